### rtl/rnic_pkg.sv
`default_nettype none

package rnic_pkg;

    localparam int OFFSET_W     = 40;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 12;
    localparam int RANK_W       = 3;
    localparam int NUM_EXT_REGS = 4;

    // register map
    localparam logic [CFG_IDX_W-1:0] CFG_RANK     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXT0     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EXT_LAST = 3'd4;

    // per-cycle control shared by every cell
    typedef struct packed {
        logic adv;      // offset pipeline moves
        logic accept;   // input transfer this cycle
        logic restart;  // payload of that transfer
        logic reload;   // reload start counts
    } ctl_t;

    // one slot of the offset pipeline
    typedef struct packed {
        logic                valid;
        logic                wrapped;
        logic [OFFSET_W-1:0] psum;
        logic [OFFSET_W-1:0] prod;
    } stage_t;

    typedef struct packed {
        logic [OFFSET_W-1:0] linear_offset;
        logic                wrapped;
    } result_t;

endpackage

`default_nettype wire

### rtl/rnic_if.sv
`default_nettype none

interface rnic_in_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

interface rnic_out_if;
    import rnic_pkg::*;

    logic                valid;
    logic                ready;
    logic [OFFSET_W-1:0] linear_offset;
    logic                wrapped;

    modport source (output valid, output linear_offset, output wrapped, input ready);
    modport sink   (input valid, input linear_offset, input wrapped, output ready);
endinterface

interface rnic_cfg_if;
    import rnic_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### rtl/rnic_cell.sv
`default_nettype none

module rnic_cell #(
    parameter int MAX_AXES    = 4,
    parameter int EXTENT_BITS = 11,
    parameter int AXIS        = 0
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire rnic_pkg::ctl_t                         ctl,
    input  wire logic                                   used,
    input  wire logic                                   neg,
    input  wire logic [EXTENT_BITS-1:0]                 mag,
    input  wire logic                                   carry_in,
    output logic                                        carry_out,
    output logic                                        zero_used,
    output logic [EXTENT_BITS-2:0]                      cnt_emit,
    input  wire logic [rnic_pkg::OFFSET_W-1:0]          stride_in,
    output logic [rnic_pkg::OFFSET_W-1:0]               stride_out,
    input  wire logic [MAX_AXES*(EXTENT_BITS-1)-1:0]    cnt_vec_in,
    output logic [MAX_AXES*(EXTENT_BITS-1)-1:0]         cnt_vec_out,
    input  wire rnic_pkg::stage_t                       stg_in,
    output rnic_pkg::stage_t                            stg_out
);
    import rnic_pkg::*;

    localparam int CW = EXTENT_BITS - 1;

    logic [CW-1:0]          cnt_reg, cnt_next;
    logic [CW-1:0]          start_cnt;
    logic [CW-1:0]          cnt_adv;
    logic [EXTENT_BITS-1:0] mag_m1;
    logic [EXTENT_BITS-1:0] cnt_inc;
    logic [EXTENT_BITS-1:0] mag_eff;
    logic [OFFSET_W-1:0]    stride_reg, stride_next;
    logic [MAX_AXES*CW-1:0] cnt_vec_reg;
    stage_t                 stg_reg, stg_next;

    assign mag_m1    = mag - EXTENT_BITS'(1);
    assign start_cnt = (used && neg) ? mag_m1[CW-1:0] : '0;
    assign cnt_emit  = ctl.restart ? start_cnt : cnt_reg;
    assign zero_used = used && (mag == '0);
    assign cnt_inc   = EXTENT_BITS'(cnt_emit) + EXTENT_BITS'(1);

    // one digit of the mixed-radix counter
    always_comb
    begin
        cnt_adv   = cnt_emit;
        carry_out = 1'b0;
        if (!used)
        begin
            carry_out = carry_in;
        end
        else if (carry_in && (mag != '0))
        begin
            if (!neg)
            begin
                if (cnt_inc == mag)
                begin
                    cnt_adv   = '0;
                    carry_out = 1'b1;
                end
                else
                begin
                    cnt_adv = cnt_inc[CW-1:0];
                end
            end
            else if (cnt_emit == '0)
            begin
                cnt_adv   = mag_m1[CW-1:0];
                carry_out = 1'b1;
            end
            else
            begin
                cnt_adv = cnt_emit - CW'(1);
            end
        end
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (ctl.reload)
        begin
            cnt_next = start_cnt;
        end
        else if (ctl.accept)
        begin
            cnt_next = cnt_adv;
        end
    end

    // stride of the next outer axis, settles one cell per cycle
    assign mag_eff     = used ? mag : EXTENT_BITS'(1);
    assign stride_next = stride_in * OFFSET_W'(mag_eff);
    assign stride_out  = stride_reg;

    // offset pipeline: add the previous cell's product, form this one
    always_comb
    begin
        stg_next.valid   = stg_in.valid;
        stg_next.wrapped = stg_in.wrapped;
        stg_next.psum    = stg_in.psum + stg_in.prod;
        stg_next.prod    = OFFSET_W'(cnt_vec_in[AXIS*CW +: CW]) * stride_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            stride_reg <= OFFSET_W'(1);
            stg_reg    <= '0;
        end
        else
        begin
            cnt_reg    <= cnt_next;
            stride_reg <= stride_next;
            if (ctl.adv)
            begin
                stg_reg <= stg_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.adv)
        begin
            cnt_vec_reg <= cnt_vec_in;
        end
    end

    assign stg_out     = stg_reg;
    assign cnt_vec_out = cnt_vec_reg;

endmodule

`default_nettype wire

### rtl/rnic_out_buf.sv
`default_nettype none

module rnic_out_buf (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire rnic_pkg::result_t push_data,
    output logic                   full,
    rnic_out_if.source             result
);
    import rnic_pkg::*;

    result_t    entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       pop;

    assign pop  = result.valid && result.ready;
    assign full = (cnt_reg == 2'd2);

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign result.valid         = (cnt_reg != 2'd0);
    assign result.linear_offset = entry_reg[rd_ptr_reg].linear_offset;
    assign result.wrapped       = entry_reg[rd_ptr_reg].wrapped;

endmodule

`default_nettype wire

### rtl/reversible_nd_index_counter_top.sv
// a result is valid after every cell's pipeline register and the output buffer
// throughput: one item per cycle unless the buffer is full or strides settle;
// the carry ripples combinationally through all cells. A configuration write
// holds off input while strides ripple through the cell chain, one cell per cycle
// reset: rank 0, every extent 1, all counts 0, wrapped 0, output buffer empty
`default_nettype none

module reversible_nd_index_counter_top #(
    parameter int MAX_AXES    = 4,
    parameter int EXTENT_BITS = 11
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    rnic_in_if.sink    item,
    rnic_out_if.source result,
    rnic_cfg_if.sink   cfg
);
    import rnic_pkg::*;

    localparam int CW      = EXTENT_BITS - 1;
    localparam int EXT_LIM = 1 << (EXTENT_BITS - 1);
    localparam int BUSY_W  = $clog2(MAX_AXES + 1);

    // configuration state
    logic [RANK_W-1:0]      rank_reg, rank_next;
    logic [EXTENT_BITS-1:0] mag_reg [MAX_AXES];
    logic                   neg_reg [MAX_AXES];
    logic [BUSY_W-1:0]      busy_reg, busy_next;
    logic                   wrapped_reg, wrapped_next;

    // register decode and extent saturation
    logic                   cfg_write;
    logic                   sel_rank;
    logic                   sel_ext;
    logic                   ext_neg;
    logic [CFG_DATA_W:0]    ext_abs;
    logic [EXTENT_BITS-1:0] ext_mag;

    // cell chain wiring
    logic [OFFSET_W-1:0]    stride_w [MAX_AXES];
    logic [OFFSET_W-1:0]    stride_in_w [MAX_AXES];
    logic                   carry_out_w [MAX_AXES];
    logic                   carry_in_w [MAX_AXES];
    logic [CW-1:0]          cnt_emit_w [MAX_AXES];
    logic [MAX_AXES-1:0]    zero_w;
    logic [MAX_AXES*CW-1:0] cnt_vec_w;
    logic [MAX_AXES*CW-1:0] cnt_vec_out_w [MAX_AXES];
    logic [MAX_AXES*CW-1:0] cnt_vec_in_w [MAX_AXES];
    stage_t                 stg_w [MAX_AXES];
    stage_t                 stg_in_w [MAX_AXES];
    stage_t                 stg_head;

    ctl_t                   ctl;
    logic                   busy;
    logic                   buf_full;
    logic                   accept;
    logic                   start_wrapped;
    logic                   wrapped_emit;
    logic                   push;
    result_t                push_data;

    // config channel always open; user must write only while idle, not enforced
    assign cfg.ready = 1'b1;
    assign cfg_write = cfg.valid && cfg.ready;

    always_comb
    begin
        sel_rank = 1'b0;
        sel_ext  = 1'b0;
        unique case (cfg.index) inside
            CFG_RANK:                 sel_rank = 1'b1;
            [CFG_EXT0:CFG_EXT_LAST]:  sel_ext  = 1'b1;
            default:                  ;
        endcase
    end

    // signed 12-bit extent to sign and saturated magnitude
    assign ext_neg = cfg.data[CFG_DATA_W-1];
    assign ext_abs = ext_neg ? ((CFG_DATA_W+1)'(0) - {1'b1, cfg.data}) : {1'b0, cfg.data};
    assign ext_mag = (32'(ext_abs) > EXT_LIM) ? EXTENT_BITS'(EXT_LIM)
                                              : EXTENT_BITS'(ext_abs);

    assign rank_next = (cfg_write && sel_rank) ? cfg.data[RANK_W-1:0] : rank_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rank_reg <= '0;
        end
        else
        begin
            rank_reg <= rank_next;
        end
    end

    generate
        for (genvar i = 0; i < MAX_AXES; i++)
        begin : g_ext
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    mag_reg[i] <= EXTENT_BITS'(1);
                    neg_reg[i] <= 1'b0;
                end
                else if (i < NUM_EXT_REGS && cfg_write && sel_ext &&
                         cfg.index == CFG_IDX_W'(32'(CFG_EXT0) + i))
                begin
                    mag_reg[i] <= ext_mag;
                    neg_reg[i] <= ext_neg;
                end
            end
        end
    endgenerate

    // any valid write reloads counts and waits for the stride ripple
    assign busy = (busy_reg != '0);

    always_comb
    begin
        busy_next = busy_reg;
        if (cfg_write && (sel_rank || sel_ext))
        begin
            busy_next = BUSY_W'(MAX_AXES);
        end
        else if (busy)
        begin
            busy_next = busy_reg - BUSY_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    // input side stalls when the output buffer is full or strides are settling
    assign item.ready = !buf_full && !busy;
    assign accept     = item.valid && item.ready;

    assign ctl.adv     = !buf_full;
    assign ctl.accept  = accept;
    assign ctl.restart = item.restart;
    assign ctl.reload  = busy;

    // sticky wrapped flag, set by a carry out of axis 0 or by a zero extent in use
    assign start_wrapped = |zero_w;
    assign wrapped_emit  = item.restart ? start_wrapped : wrapped_reg;

    always_comb
    begin
        wrapped_next = wrapped_reg;
        if (busy)
        begin
            wrapped_next = start_wrapped;
        end
        else if (accept)
        begin
            wrapped_next = wrapped_emit | carry_out_w[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wrapped_reg <= 1'b0;
        end
        else
        begin
            wrapped_reg <= wrapped_next;
        end
    end

    // head of the offset pipeline carries the counts of this transfer
    always_comb
    begin
        stg_head.valid   = accept;
        stg_head.wrapped = wrapped_emit;
        stg_head.psum    = '0;
        stg_head.prod    = '0;
    end

    // cell chain: axis 0 outermost; carry and stride move outward, offsets inward
    generate
        for (genvar i = 0; i < MAX_AXES; i++)
        begin : g_cell
            assign cnt_vec_w[i*CW +: CW] = cnt_emit_w[i];

            if (i == MAX_AXES - 1)
            begin : g_inner
                assign carry_in_w[i]  = 1'b1;
                assign stride_in_w[i] = OFFSET_W'(1);
            end
            else
            begin : g_mid
                assign carry_in_w[i]  = carry_out_w[i+1];
                assign stride_in_w[i] = stride_w[i+1];
            end

            if (i == 0)
            begin : g_outer
                assign stg_in_w[i]     = stg_head;
                assign cnt_vec_in_w[i] = cnt_vec_w;
            end
            else
            begin : g_next
                assign stg_in_w[i]     = stg_w[i-1];
                assign cnt_vec_in_w[i] = cnt_vec_out_w[i-1];
            end

            rnic_cell #(
                .MAX_AXES    (MAX_AXES),
                .EXTENT_BITS (EXTENT_BITS),
                .AXIS        (i)
            ) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctl         (ctl),
                .used        (32'(rank_reg) > i),
                .neg         (neg_reg[i]),
                .mag         (mag_reg[i]),
                .carry_in    (carry_in_w[i]),
                .carry_out   (carry_out_w[i]),
                .zero_used   (zero_w[i]),
                .cnt_emit    (cnt_emit_w[i]),
                .stride_in   (stride_in_w[i]),
                .stride_out  (stride_w[i]),
                .cnt_vec_in  (cnt_vec_in_w[i]),
                .cnt_vec_out (cnt_vec_out_w[i]),
                .stg_in      (stg_in_w[i]),
                .stg_out     (stg_w[i])
            );
        end
    endgenerate

    // last product joins the sum on its way into the output buffer
    assign push                    = ctl.adv && stg_w[MAX_AXES-1].valid;
    assign push_data.linear_offset = stg_w[MAX_AXES-1].psum + stg_w[MAX_AXES-1].prod;
    assign push_data.wrapped       = stg_w[MAX_AXES-1].wrapped;

    rnic_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (buf_full),
        .result    (result)
    );

endmodule

`default_nettype wire

### rtl/rnic_checker.sv
`default_nettype none

module rnic_checker #(
    parameter int MAX_AXES = 4
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    rnic_in_if.sink    item,
    rnic_out_if.source result,
    rnic_cfg_if.sink   cfg
);
    import rnic_pkg::*;

    localparam int OUT_W = $clog2(MAX_AXES + 4) + 1;

    logic [OUT_W-1:0] pend_reg, pend_next;
    logic             in_xfer;
    logic             out_xfer;

    assign in_xfer   = item.valid && item.ready;
    assign out_xfer  = result.valid && result.ready;
    assign pend_next = pend_reg + OUT_W'(in_xfer) - OUT_W'(out_xfer);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    // a stalled result holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.ready |=>
            result.valid && $stable(result.linear_offset) && $stable(result.wrapped))
        else $error("result changed while stalled");

    // a register write closes the input while strides settle
    a_cfg_holdoff: assert property (@(posedge clk) disable iff (!rst_n)
        cfg.valid && cfg.ready && (cfg.index == CFG_RANK ||
            (cfg.index >= CFG_EXT0 && cfg.index <= CFG_EXT_LAST)) |=> !item.ready)
        else $error("input open right after a register write");

    // no result without an item in flight
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> pend_reg != '0)
        else $error("result with no item outstanding");

    // items in flight never exceed the cell chain plus the output buffer
    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        32'(pend_reg) <= MAX_AXES + 2)
        else $error("too many items in flight");

endmodule

bind reversible_nd_index_counter_top rnic_checker #(
    .MAX_AXES (MAX_AXES)
) u_rnic_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .item   (item),
    .result (result),
    .cfg    (cfg)
);

`default_nettype wire

### test/offset_checker.sv
`timescale 1ns / 1ps

module offset_checker #(
    parameter int MAX_AXES    = 4,
    parameter int EXTENT_BITS = 11
) (
    input  logic clk,
    input  logic rst_n,
    rnic_in_if   item,
    rnic_out_if  result,
    rnic_cfg_if  cfg,
    output int   fail_count,
    output int   pending
);
    import rnic_pkg::*;

    logic [RANK_W-1:0]            rank_q;
    logic signed [CFG_DATA_W-1:0] extent_q [MAX_AXES];
    logic [EXTENT_BITS-1:0]       count_q  [MAX_AXES];
    logic                         wrapped_q;

    result_t offset_due [$];
    int      errors = 0;

    function automatic int axes_in_use();
        return (int'(rank_q) > MAX_AXES) ? MAX_AXES : int'(rank_q);
    endfunction

    function automatic int clamp_extent(logic signed [CFG_DATA_W-1:0] e);
        int lim;
        int v;
        lim = 1 << (EXTENT_BITS - 1);
        v   = e;
        if (v > lim)
        begin
            return lim;
        end
        if (v < -lim)
        begin
            return -lim;
        end
        return v;
    endfunction

    function automatic int magnitude(int v);
        return (v < 0) ? -v : v;
    endfunction

    // start counts: reversed axes begin at their top
    task automatic restart_counts();
        int r;
        int e;
        r         = axes_in_use();
        wrapped_q = 1'b0;
        for (int a = 0; a < MAX_AXES; a++)
        begin
            e          = clamp_extent(extent_q[a]);
            count_q[a] = '0;
            if (a < r)
            begin
                if (e == 0)
                begin
                    wrapped_q = 1'b1;
                end
                if (e < 0)
                begin
                    count_q[a] = EXTENT_BITS'(magnitude(e) - 1);
                end
            end
        end
    endtask

    function automatic logic [OFFSET_W-1:0] offset_now();
        logic [63:0] sum;
        logic [63:0] stride;
        sum    = '0;
        stride = 64'd1;
        for (int a = axes_in_use() - 1; a >= 0; a--)
        begin
            sum    += 64'(count_q[a]) * stride;
            stride *= 64'(magnitude(clamp_extent(extent_q[a])));
        end
        return sum[OFFSET_W-1:0];
    endfunction

    // innermost axis first, carry outward; a zero extent swallows the carry
    task automatic advance_counts();
        int e;
        int c;
        for (int a = axes_in_use() - 1; a >= 0; a--)
        begin
            e = clamp_extent(extent_q[a]);
            c = count_q[a];
            if (e > 0)
            begin
                c++;
                if (c < e)
                begin
                    count_q[a] = EXTENT_BITS'(c);
                    return;
                end
                count_q[a] = '0;
            end
            else if (e < 0)
            begin
                if (c != 0)
                begin
                    count_q[a] = EXTENT_BITS'(c - 1);
                    return;
                end
                count_q[a] = EXTENT_BITS'(magnitude(e) - 1);
            end
            else
            begin
                return;
            end
        end
        wrapped_q = 1'b1;
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        if (idx == CFG_RANK)
        begin
            rank_q = data[RANK_W-1:0];
            restart_counts();
        end
        else if (idx >= CFG_EXT0 && idx <= CFG_EXT_LAST)
        begin
            if (int'(idx - CFG_EXT0) < MAX_AXES)
            begin
                extent_q[idx - CFG_EXT0] = data;
            end
            restart_counts();
        end
    endtask

    task automatic log_error(string msg);
        $display("%0t offset_checker: %s", $time, msg);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t due;
        if (!rst_n)
        begin
            rank_q = '0;
            for (int a = 0; a < MAX_AXES; a++)
            begin
                extent_q[a] = CFG_DATA_W'(1);
            end
            restart_counts();
            offset_due.delete();
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                if (offset_due.size() == 0)
                begin
                    log_error($sformatf("result with nothing due: offset %0h wrapped %0b",
                                        result.linear_offset, result.wrapped));
                end
                else
                begin
                    due = offset_due.pop_front();
                    if (result.linear_offset !== due.linear_offset)
                    begin
                        log_error($sformatf("linear_offset expected %0h got %0h",
                                            due.linear_offset, result.linear_offset));
                    end
                    if (result.wrapped !== due.wrapped)
                    begin
                        log_error($sformatf("wrapped expected %0b got %0b",
                                            due.wrapped, result.wrapped));
                    end
                end
            end
            if (cfg.valid && cfg.ready)
            begin
                write_register(cfg.index, cfg.data);
            end
            if (item.valid && item.ready)
            begin
                if (item.restart)
                begin
                    restart_counts();
                end
                due.linear_offset = offset_now();
                due.wrapped       = wrapped_q;
                offset_due.push_back(due);
                advance_counts();
            end
        end
        fail_count <= errors;
        pending    <= offset_due.size();
    end

endmodule

### test/reversible_nd_index_counter_top_tb.sv
`timescale 1ns / 1ps

module reversible_nd_index_counter_top_tb;
    import rnic_pkg::*;

    localparam int MAX_AXES    = 4;
    localparam int EXTENT_BITS = 11;
    localparam int ITEM_GOAL   = 900;     // random items after the directed part
    localparam int CALM_ITEMS  = 100;     // last stretch runs with no idling
    localparam int CYCLE_LIMIT = 400000;

    logic clk;
    logic rst_n;

    rnic_in_if  item_ch ();
    rnic_out_if result_ch ();
    rnic_cfg_if cfg_ch ();

    int fail_count;
    int pending;
    int items_sent = 0;
    int cycles     = 0;
    bit idle_on    = 1'b1;

    reversible_nd_index_counter_top #(
        .MAX_AXES    (MAX_AXES),
        .EXTENT_BITS (EXTENT_BITS)
    ) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    // watches all three channels, predicts every offset and compares
    offset_checker #(
        .MAX_AXES    (MAX_AXES),
        .EXTENT_BITS (EXTENT_BITS)
    ) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item_ch),
        .result     (result_ch),
        .cfg        (cfg_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // 20 ns clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // hard stop in case a handshake never completes
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("** reversible_nd_index_counter_top: FAILED **");
            $finish;
        end
    end

    // result side: ready drops in random bursts while idling is on
    initial
    begin
        int stall;
        stall = 0;
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall == 0 && idle_on && $urandom_range(0, 9) == 0)
            begin
                stall = $urandom_range(1, 17);
            end
            if (stall > 0)
            begin
                result_ch.ready <= 1'b0;
                stall--;
            end
            else
            begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    // one input transfer; valid stays high afterward so items can go back to back
    task automatic send_item(logic restart);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            item_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        item_ch.valid   <= 1'b1;
        item_ch.restart <= restart;
        @(posedge clk);
        while (!item_ch.ready)
        begin
            @(posedge clk);
        end
        items_sent++;
    endtask

    task automatic end_items();
        item_ch.valid <= 1'b0;
    endtask

    // one register write transfer; valid is lowered by cfg_release
    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        @(posedge clk);
        while (!cfg_ch.ready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic cfg_release();
        cfg_ch.valid <= 1'b0;
    endtask

    // wait until every offset has come back, then let the pipeline empty out
    task automatic settle();
        do
        begin
            @(posedge clk);
        end
        while (pending != 0);
        repeat (MAX_AXES + 2) @(posedge clk);
    endtask

    // mostly small ranks, some zero and some past the axis count
    function automatic int pick_rank();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
        begin
            return 0;
        end
        if (r == 1)
        begin
            return $urandom_range(MAX_AXES + 1, 7);
        end
        return $urandom_range(1, MAX_AXES);
    endfunction

    // small magnitudes keep traversals short enough to wrap often
    function automatic logic [CFG_DATA_W-1:0] pick_extent();
        int r;
        int m;
        r = $urandom_range(0, 19);
        if (r == 0)
        begin
            return '0;
        end
        if (r == 1)
        begin
            return CFG_DATA_W'($urandom);
        end
        if (r == 2)
        begin
            m = 1 << (EXTENT_BITS - 1);
            return $urandom_range(0, 1) ? CFG_DATA_W'(m) : CFG_DATA_W'(-m);
        end
        m = $urandom_range(1, 3);
        return (r < 11) ? CFG_DATA_W'(m) : CFG_DATA_W'(-m);
    endfunction

    initial
    begin
        int  n;
        bit  wrote;
        logic [CFG_DATA_W-1:0] d;

        rst_n           <= 1'b0;
        item_ch.valid   <= 1'b0;
        item_ch.restart <= 1'b0;
        cfg_ch.valid    <= 1'b0;
        cfg_ch.index    <= CFG_RANK;
        cfg_ch.data     <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // reset setting: zero rank, offset 0, wraps after the first step,
        // restart clears the flag again
        send_item(1'b0);
        send_item(1'b0);
        send_item(1'b1);
        end_items();
        settle();

        // two axes, inner one reversed: full traversal then wrap, then restart
        cfg_write(CFG_RANK, CFG_DATA_W'(2));
        cfg_write(CFG_EXT0, CFG_DATA_W'(2));
        cfg_write(CFG_EXT0 + CFG_IDX_W'(1), CFG_DATA_W'(-3));
        cfg_release();
        repeat (7) send_item(1'b0);
        send_item(1'b1);
        end_items();
        settle();

        // full rank at the extremes; out-of-range extents saturate with sign kept
        cfg_write(CFG_RANK, CFG_DATA_W'(MAX_AXES));
        cfg_write(CFG_EXT0, 12'h400);
        cfg_write(CFG_EXT0 + CFG_IDX_W'(1), 12'hC00);
        cfg_write(CFG_EXT0 + CFG_IDX_W'(2), 12'h7FF);
        cfg_write(CFG_EXT0 + CFG_IDX_W'(3), 12'h800);
        cfg_release();
        repeat (3) send_item(1'b0);
        end_items();
        settle();

        // rank past the axis count, a zero extent in use (wrapped at once),
        // writes past the register map are dropped
        cfg_write(CFG_RANK, 12'hFFF);
        cfg_write(CFG_EXT0 + CFG_IDX_W'(2), 12'h000);
        cfg_write(CFG_EXT0 + CFG_IDX_W'(3), 12'hFFF);
        for (int k = 1; k <= 3; k++)
        begin
            cfg_write(CFG_EXT_LAST + CFG_IDX_W'(k), 12'hFFF);
        end
        cfg_release();
        send_item(1'b0);
        send_item(1'b1);
        end_items();
        settle();

        // back to zero rank with everything else left set
        cfg_write(CFG_RANK, 12'h000);
        cfg_release();
        send_item(1'b0);
        send_item(1'b0);
        end_items();
        settle();

        // random phases: new settings between phases, counts carry on otherwise
        items_sent = 0;
        while (items_sent < ITEM_GOAL)
        begin
            if (items_sent >= ITEM_GOAL - CALM_ITEMS)
            begin
                idle_on = 1'b0;
            end
            else
            begin
                idle_on = ($urandom_range(0, 3) != 0);
            end

            if ($urandom_range(0, 3) != 0)
            begin
                wrote = 1'b0;
                if ($urandom_range(0, 1) == 1)
                begin
                    d              = CFG_DATA_W'($urandom);
                    d[RANK_W-1:0]  = RANK_W'(pick_rank());
                    cfg_write(CFG_RANK, d);
                    wrote = 1'b1;
                end
                for (int k = 0; k < MAX_AXES; k++)
                begin
                    if ($urandom_range(0, 1) == 1)
                    begin
                        cfg_write(CFG_EXT0 + CFG_IDX_W'(k), pick_extent());
                        wrote = 1'b1;
                    end
                end
                // stray write past the register map
                if ($urandom_range(0, 9) == 0)
                begin
                    cfg_write(CFG_EXT_LAST + CFG_IDX_W'($urandom_range(1, 3)),
                              CFG_DATA_W'($urandom));
                end
                if (!wrote)
                begin
                    cfg_write(CFG_RANK, CFG_DATA_W'(pick_rank()));
                end
                cfg_release();
            end

            n = $urandom_range(10, 60);
            repeat (n) send_item($urandom_range(0, 19) == 0);
            end_items();
            settle();
        end

        do
        begin
            @(posedge clk);
        end
        while (pending != 0);
        repeat (8 * MAX_AXES) @(posedge clk);

        if (fail_count == 0 && pending == 0)
        begin
            $display("** reversible_nd_index_counter_top: PASSED **");
        end
        else
        begin
            $display("** reversible_nd_index_counter_top: FAILED **");
        end
        $finish;
    end

endmodule
